// ----- rtl/cstk_pkg.sv -----
// shared constants and types for the cosine similarity top-k block
`default_nettype none
package cstk_pkg;
  localparam int unsigned VecMax   = 512;
  localparam int unsigned TopkMax  = 64;
  localparam int unsigned KeepW    = 7;
  localparam logic [6:0]  KeepReset = 7'd40;
  localparam int unsigned IdW      = 20;
  localparam int unsigned ElemW    = 16;
  localparam int unsigned AccW     = 44;

  typedef enum logic [1:0] {
    KIND_QUERY  = 2'd0,
    KIND_CAND   = 2'd1,
    KIND_FINISH = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;
endpackage
`default_nettype wire

// ----- rtl/cstk_ram.sv -----
// generic single-port ram with registered read
`default_nettype none
module cstk_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 512
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // write or read one word a cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule
`default_nettype wire

// ----- rtl/cstk_score.sv -----
// iterative score unit: bisection over m with one shared multiplier
`default_nettype none
module cstk_score (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic signed [cstk_pkg::AccW-1:0] dot_i,
  input  wire logic [cstk_pkg::AccW-1:0]  nq_i,
  input  wire logic [cstk_pkg::AccW-1:0]  nc_i,
  output logic                            done_o,
  output logic signed [15:0]              score_o
);
  import cstk_pkg::*;

  // p = nq*nc and d2<<32 need 88 and 120 bits; products are done bit-serially
  localparam int unsigned PW = 2 * AccW;
  localparam int unsigned RW = 2 * AccW + 32;
  localparam int unsigned TW = 32;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_P    = 6'b000010,
    S_D2   = 6'b000100,
    S_MID  = 6'b001000,
    S_TEST = 6'b010000,
    S_DONE = 6'b100000
  } st_e;

  st_e            st_q, st_d;
  logic [AccW-1:0] ad_q;
  logic            neg_q;
  logic [PW-1:0]   p_q;
  logic [RW-1:0]   rhs_q;
  logic [RW-1:0]   acc_q;
  logic [RW-1:0]   mcand_q;
  logic [AccW-1:0] mplier_q;
  logic [6:0]      bit_q;
  logic [16:0]     lo_q, hi_q, mid_q;
  logic [TW-1:0]   t_q;
  logic [1:0]      tph_q;

  logic [16:0] mid_w;
  logic [17:0] two_m;
  assign mid_w = 17'((18'(lo_q) + 18'(hi_q) + 18'd1) >> 1);
  assign two_m = {mid_w, 1'b0} - 18'd1;

  // sequencer: shift-add multiply for p, d2, t*t and p*t2, then compare
  always_comb begin
    st_d = st_q;
    case (st_q)
      S_IDLE: if (start_i) st_d = S_P;
      S_P:    if (bit_q == 7'(AccW - 1)) st_d = S_D2;
      S_D2:   if (bit_q == 7'(AccW - 1)) st_d = S_MID;
      S_MID:  st_d = (lo_q < hi_q) ? S_TEST : S_DONE;
      S_TEST: if (tph_q == 2'd1 && bit_q == 7'(2 * TW - 1)) st_d = S_MID;
      S_DONE: st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (st_q)
      S_IDLE: begin
        if (start_i) begin
          neg_q    <= dot_i[AccW-1];
          ad_q     <= dot_i[AccW-1] ? AccW'(-dot_i) : AccW'(dot_i);
          mcand_q  <= RW'(nq_i);
          mplier_q <= nc_i;
          acc_q    <= '0;
          bit_q    <= '0;
          lo_q     <= '0;
          hi_q     <= 17'd32768;
        end
      end
      S_P: begin
        if (mplier_q[0]) acc_q <= acc_q + mcand_q;
        mcand_q  <= mcand_q << 1;
        mplier_q <= mplier_q >> 1;
        bit_q    <= bit_q + 7'd1;
        if (bit_q == 7'(AccW - 1)) begin
          p_q      <= PW'(mplier_q[0] ? acc_q + mcand_q : acc_q);
          acc_q    <= '0;
          mcand_q  <= RW'(ad_q) << 32;
          mplier_q <= ad_q;
          bit_q    <= '0;
        end
      end
      S_D2: begin
        if (mplier_q[0]) acc_q <= acc_q + mcand_q;
        mcand_q  <= mcand_q << 1;
        mplier_q <= mplier_q >> 1;
        bit_q    <= bit_q + 7'd1;
        if (bit_q == 7'(AccW - 1)) begin
          rhs_q <= mplier_q[0] ? acc_q + mcand_q : acc_q;
        end
      end
      S_MID: begin
        // first form t*t, then p*t2
        mid_q    <= mid_w;
        t_q      <= TW'(two_m);
        acc_q    <= '0;
        mcand_q  <= RW'(two_m);
        mplier_q <= AccW'(two_m);
        bit_q    <= '0;
        tph_q    <= 2'd0;
      end
      S_TEST: begin
        if (tph_q == 2'd0) begin
          if (mplier_q[0]) acc_q <= acc_q + mcand_q;
          mcand_q  <= mcand_q << 1;
          mplier_q <= mplier_q >> 1;
          bit_q    <= bit_q + 7'd1;
          if (bit_q == 7'd17) begin
            t_q      <= TW'(mplier_q[0] ? acc_q + mcand_q : acc_q);
            acc_q    <= '0;
            mcand_q  <= RW'(p_q);
            bit_q    <= '0;
            tph_q    <= 2'd1;
          end
        end else begin
          if (t_q[bit_q[4:0]]) acc_q <= acc_q + mcand_q;
          mcand_q <= mcand_q << 1;
          bit_q   <= bit_q + 7'd1;
          if (bit_q == 7'(TW - 1)) begin
            bit_q <= 7'(2 * TW - 1);
          end
          if (bit_q == 7'(2 * TW - 1)) begin
            if (acc_q <= rhs_q) lo_q <= mid_q;
            else                hi_q <= mid_q - 17'd1;
          end
        end
      end
      default: ;
    endcase
  end

  assign done_o  = (st_q == S_DONE);
  assign score_o = neg_q ? -16'(lo_q) : (lo_q[15] ? 16'sd32767 : 16'(lo_q));
endmodule
`default_nettype wire

// ----- rtl/cosine_similarity_top_k_top.sv -----
// top level: query store, accumulators, score unit, kept list and emission
`default_nettype none
// Cosine similarity top-k search. A query element is taken while idle and
// busy stays low. A candidate element keeps busy high after it is accepted,
// through the ram read, multiply and accumulate states (T_RD, T_MAC, T_UPD),
// so no new candidate item is taken until the last one is through. A scored
// candidate's last element also runs the bit-serial score unit, which forms
// the norm and dot products and then takes up to 16 bisection steps, and
// then a list insertion that compares entries from the lowest upwards. A
// finish item emits one result per cycle on result_valid_o, which cannot be
// stalled, and keeps busy high until the final result.
module cosine_similarity_top_k_top #(
  parameter int unsigned VecMaxP = cstk_pkg::VecMax
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  kind_i,
  input  wire logic signed [15:0] element_i,
  input  wire logic        last_i,
  input  wire logic [19:0] cand_id_i,
  input  wire logic        skip_i,
  output logic             result_valid_o,
  output logic [19:0]      word_id_o,
  output logic signed [15:0] similarity_o,
  output logic             empty_res_o,
  output logic             last_result_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [0:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import cstk_pkg::*;

  localparam int unsigned AW = $clog2(VecMaxP);
  localparam int unsigned CW = $clog2(VecMaxP + 1);
  localparam int unsigned LW = $clog2(TopkMax);

  typedef enum logic [8:0] {
    T_IDLE  = 9'b000000001,
    T_RD    = 9'b000000010,
    T_MAC   = 9'b000000100,
    T_SCORE = 9'b000001000,
    T_RDL   = 9'b000010000,
    T_EMIT  = 9'b000100000,
    T_UPD   = 9'b001000000,
    T_CMP   = 9'b010000000,
    T_WR    = 9'b100000000
  } st_e;

  st_e st_q;
  logic [6:0] keep_q;
  logic [CW-1:0] qlen_q, eidx_q;
  logic [AccW-1:0] qnorm_q, cnorm_q;
  logic signed [AccW-1:0] dot_q;
  logic qdone_q;
  logic [6:0] cnt_q;
  logic [1:0] kind_q;
  logic signed [15:0] el_q;
  logic last_q, skip_q;
  logic [19:0] cid_q;
  logic signed [31:0] prod_q;
  logic [6:0] pos_q, emi_q;
  logic signed [15:0] new_sc_q;
  logic full_q;

  // config port
  assign pready = 1'b1;
  assign prdata = paddr == 1'b0 ? {25'd0, keep_q} : 32'd0;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) keep_q <= KeepReset;
    else if (psel && penable && pwrite && paddr == 1'b0) keep_q <= pwdata[6:0];
  end

  logic [6:0] lim, eff;
  assign lim = keep_q == 7'd0 ? 7'd1 : (keep_q > 7'(TopkMax) ? 7'(TopkMax) : keep_q);
  assign eff = cnt_q > lim ? lim : cnt_q;

  // query store
  logic qwe;
  logic [AW-1:0] qaddr;
  logic [15:0] qrd;
  assign qwe   = st_q == T_IDLE && start && kind_i == KIND_QUERY &&
                 (qdone_q || qlen_q < CW'(VecMaxP));
  assign qaddr = st_q == T_IDLE ? (kind_i == KIND_QUERY ? (qdone_q ? '0 : AW'(qlen_q))
                                                        : AW'(eidx_q)) : AW'(eidx_q);
  cstk_ram #(.Width(16), .Depth(VecMaxP)) u_qram (
    .clk_i, .we_i(qwe), .addr_i(qaddr), .wdata_i(element_i), .rdata_o(qrd)
  );

  // kept list store: score in the upper bits, id in the lower bits
  logic lwe;
  logic [LW-1:0] laddr;
  logic [ElemW+IdW-1:0] lwd, lrd;
  logic signed [15:0] lrd_sc;
  assign lrd_sc = lrd[ElemW+IdW-1:IdW];
  always_comb begin
    case (st_q)
      T_RDL:       laddr = LW'(pos_q - 7'd1);
      T_CMP, T_WR: laddr = pos_q[LW-1:0];
      T_EMIT:      laddr = LW'(emi_q + 7'd1);
      default:     laddr = '0;
    endcase
  end
  assign lwe = (st_q == T_CMP && !full_q && lrd_sc < new_sc_q) || st_q == T_WR;
  assign lwd = st_q == T_WR ? {new_sc_q, cid_q} : lrd;
  cstk_ram #(.Width(ElemW + IdW), .Depth(TopkMax)) u_lram (
    .clk_i, .we_i(lwe), .addr_i(laddr), .wdata_i(lwd), .rdata_o(lrd)
  );

  // score unit, started once the last element is in the accumulators
  logic sc_start, sc_run, sc_done;
  logic signed [15:0] sc_w;
  assign sc_run = st_q == T_SCORE;
  cstk_score u_score (
    .clk_i, .rst_ni, .start_i(sc_run), .dot_i(dot_q), .nq_i(qnorm_q),
    .nc_i(cnorm_q), .done_o(sc_done), .score_o(sc_w)
  );

  assign busy = st_q != T_IDLE;
  logic ok_elem;
  assign ok_elem = eidx_q < qlen_q && eidx_q < CW'(VecMaxP);
  assign sc_start = st_q == T_UPD && kind_q == KIND_CAND && last_q && !skip_q &&
                    qnorm_q != '0 && (cnorm_q + (ok_elem ? AccW'($unsigned(
                    32'(el_q * el_q))) : '0)) != '0;

  // control and datapath
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= T_IDLE; qlen_q <= '0; eidx_q <= '0; qnorm_q <= '0; cnorm_q <= '0;
      dot_q <= '0; qdone_q <= 1'b0; cnt_q <= '0; result_valid_o <= 1'b0;
    end else begin
      result_valid_o <= 1'b0;
      case (st_q)
        T_IDLE: if (start) begin
          kind_q <= kind_i; el_q <= element_i; last_q <= last_i;
          cid_q <= cand_id_i; skip_q <= skip_i;
          case (kind_i)
            KIND_QUERY: begin
              dot_q <= '0; cnorm_q <= '0; eidx_q <= '0;
              if (qdone_q) begin
                qlen_q <= CW'(1); qdone_q <= 1'b0;
                qnorm_q <= AccW'($unsigned(32'(element_i * element_i)));
              end else if (qlen_q < CW'(VecMaxP)) begin
                qlen_q <= qlen_q + CW'(1);
                qnorm_q <= qnorm_q + AccW'($unsigned(32'(element_i * element_i)));
              end
              if (last_i) qdone_q <= 1'b1;
            end
            KIND_CAND:   st_q <= T_RD;
            KIND_FINISH: begin st_q <= T_EMIT; emi_q <= '0; end
            default: ;
          endcase
        end
        T_RD: st_q <= T_MAC;
        T_MAC: begin
          prod_q <= $signed(qrd) * el_q;
          st_q <= T_UPD;
        end
        T_UPD: begin
          if (ok_elem) begin
            dot_q <= dot_q + AccW'(prod_q);
            cnorm_q <= cnorm_q + AccW'($unsigned(32'(el_q * el_q)));
          end
          if (eidx_q < CW'(VecMaxP)) eidx_q <= eidx_q + CW'(1);
          st_q <= T_IDLE;
          if (last_q) begin
            eidx_q <= '0;
            if (sc_start) st_q <= T_SCORE;
            else begin dot_q <= '0; cnorm_q <= '0; end
          end
        end
        T_SCORE: if (sc_done) begin
          // cut the list to the current limit, then check the lowest entry when full
          dot_q <= '0; cnorm_q <= '0;
          new_sc_q <= sc_w;
          cnt_q <= eff;
          pos_q <= eff;
          full_q <= eff >= lim;
          st_q <= (eff == 7'd0) ? T_WR : T_RDL;
        end
        T_RDL: st_q <= T_CMP;
        T_CMP: begin
          if (full_q) begin
            // full list: enter only above the lowest, which is dropped
            if (new_sc_q <= lrd_sc) st_q <= T_IDLE;
            else begin
              full_q <= 1'b0;
              cnt_q <= lim - 7'd1;
              pos_q <= lim - 7'd1;
              st_q <= (lim == 7'd1) ? T_WR : T_RDL;
            end
          end else if (lrd_sc < new_sc_q) begin
            // entry above moved down one slot
            pos_q <= pos_q - 7'd1;
            st_q <= (pos_q == 7'd1) ? T_WR : T_RDL;
          end else st_q <= T_WR;
        end
        T_WR: begin
          cnt_q <= cnt_q + 7'd1;
          st_q <= T_IDLE;
        end
        T_EMIT: begin
          result_valid_o <= 1'b1;
          if (cnt_q == 7'd0) begin
            word_id_o <= '0; similarity_o <= '0; empty_res_o <= 1'b1;
            last_result_o <= 1'b1; st_q <= T_IDLE;
          end else begin
            word_id_o <= lrd[IdW-1:0]; similarity_o <= lrd_sc;
            empty_res_o <= 1'b0;
            last_result_o <= emi_q + 7'd1 == cnt_q;
            emi_q <= emi_q + 7'd1;
            if (emi_q + 7'd1 == cnt_q) begin cnt_q <= '0; st_q <= T_IDLE; end
          end
        end
        default: st_q <= T_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
